// ===== rtl/skga_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skga_pkg
// Shared constants and helpers for the sorted key group aggregator.
// ----------------------------------------------------------------------------
package skga_pkg;

  localparam int BUCKET_BITS_DEF  = 15;
  localparam int FIXED_WEIGHT_DEF = 100;

  localparam int KEY_W  = 64;
  localparam int WORD_W = 32;

  localparam logic KIND_UNIQUE  = 1'b0;
  localparam logic KIND_CLUSTER = 1'b1;

  localparam logic REG_FIXED_WEIGHT = 1'b0;
  localparam logic REG_LOWER_BOUND  = 1'b1;

  function automatic logic [WORD_W-1:0] sat_inc(input logic [WORD_W-1:0] v);
    sat_inc = (&v) ? v : v + WORD_W'(1);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/sorted_key_group_aggregator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_key_group_aggregator
// Collapses a key-sorted record stream into groups, closes bucket clusters
// and reports running totals; key 0 ends a stream.
// ----------------------------------------------------------------------------
// Input transfers are held in the input register; results go to the queue.
// Throughput: one input item per cycle while the queue has two free entries;
//   an item closing a group and a cluster puts two results into the 4-entry
//   queue, drained one per unstalled cycle through the single output port.
// Reset: synchronous, active low; clears all stream state, the queue and
//   both configuration registers.
module sorted_key_group_aggregator #(
  parameter int BUCKET_BITS  = skga_pkg::BUCKET_BITS_DEF,
  parameter int FIXED_WEIGHT = skga_pkg::FIXED_WEIGHT_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,

  input  wire logic                           cfg_valid,
  output      logic                           cfg_ready,
  input  wire logic                           cfg_index,
  input  wire logic [skga_pkg::WORD_W-1:0]    cfg_data,

  input  wire logic                           in_valid,
  output      logic                           in_stall,
  input  wire logic [skga_pkg::KEY_W-1:0]     in_key,
  input  wire logic [skga_pkg::WORD_W-1:0]    in_flag_mask,

  output      logic                           out_valid,
  input  wire logic                           out_stall,
  output      logic                           out_kind,
  output      logic [skga_pkg::KEY_W-1:0]     out_key,
  output      logic [skga_pkg::WORD_W-1:0]    out_occurrences,
  output      logic [skga_pkg::WORD_W-1:0]    out_merged_flags,
  output      logic [BUCKET_BITS-1:0]         out_bucket,
  output      logic [skga_pkg::WORD_W-1:0]    out_cluster_size,
  output      logic [skga_pkg::WORD_W-1:0]    out_unique_total,
  output      logic [skga_pkg::WORD_W-1:0]    out_rare_total,
  output      logic [skga_pkg::WORD_W-1:0]    out_largest_cluster,
  output      logic                           out_last
);
  import skga_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef struct packed {
    logic                   kind;
    logic [KEY_W-1:0]       key;
    logic [WORD_W-1:0]      occ;
    logic [WORD_W-1:0]      flags;
    logic [BUCKET_BITS-1:0] bkt;
    logic [WORD_W-1:0]      size;
    logic [WORD_W-1:0]      uniq;
    logic [WORD_W-1:0]      rare;
    logic [WORD_W-1:0]      largest;
    logic                   last;
  } rec_t;

  // configuration
  logic              mode_r;
  logic [WORD_W-1:0] lb_r;

  // input register
  logic              v_r;
  logic [KEY_W-1:0]  key_r;
  logic [WORD_W-1:0] flags_r;

  // stream state
  logic                   have_r, have_nxt;
  logic [KEY_W-1:0]       gkey_r, gkey_nxt;
  logic [WORD_W-1:0]      gcnt_r, gcnt_nxt;
  logic [WORD_W-1:0]      gflags_r, gflags_nxt;
  logic [BUCKET_BITS-1:0] obkt_r, obkt_nxt;
  logic [WORD_W-1:0]      members_r, members_nxt;
  logic [WORD_W-1:0]      unique_r, unique_nxt;
  logic [WORD_W-1:0]      rare_r, rare_nxt;
  logic [WORD_W-1:0]      max_r, max_nxt;

  // result queue
  rec_t             q_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  logic                   adv, proc, pop;
  logic [1:0]             push_n;
  rec_t                   r0, r1, hd;
  logic [BUCKET_BITS-1:0] bkt_in;
  logic [WORD_W-1:0]      uniq_c, mem_c, max_c, rare_c, start_cnt;

  assign cfg_ready = 1'b1;
  assign adv       = cnt_r <= CNT_W'(DEPTH - 2);
  assign in_stall  = v_r && !adv;
  assign proc      = v_r && adv;
  assign pop       = out_valid && !out_stall;

  assign bkt_in    = key_r[KEY_W-1 -: BUCKET_BITS];
  assign uniq_c    = sat_inc(unique_r);
  assign mem_c     = sat_inc(members_r);
  assign max_c     = (mem_c > max_r) ? mem_c : max_r;
  assign rare_c    = (gcnt_r < lb_r) ? sat_inc(rare_r) : rare_r;
  assign start_cnt = mode_r ? WORD_W'(FIXED_WEIGHT) : WORD_W'(1);

  always_comb begin
    have_nxt    = have_r;
    gkey_nxt    = gkey_r;
    gcnt_nxt    = gcnt_r;
    gflags_nxt  = gflags_r;
    obkt_nxt    = obkt_r;
    members_nxt = members_r;
    unique_nxt  = unique_r;
    rare_nxt    = rare_r;
    max_nxt     = max_r;
    push_n      = 2'd0;
    r0          = '0;
    r1          = '0;

    if (proc) begin
      if (key_r == '0) begin
        if (have_r) begin
          r0.kind    = KIND_UNIQUE;
          r0.key     = gkey_r;
          r0.occ     = gcnt_r;
          r0.flags   = gflags_r;
          r0.uniq    = uniq_c;
          r0.rare    = rare_c;
          r0.largest = max_c;
          r1.kind    = KIND_CLUSTER;
          r1.bkt     = obkt_r;
          r1.size    = mem_c;
          r1.uniq    = uniq_c;
          r1.rare    = rare_c;
          r1.largest = max_c;
          r1.last    = 1'b1;
          push_n     = 2'd2;
        end else begin
          r0.kind    = KIND_CLUSTER;
          r0.uniq    = unique_r;
          r0.rare    = rare_r;
          r0.largest = max_r;
          r0.last    = 1'b1;
          push_n     = 2'd1;
        end
        have_nxt    = 1'b0;
        gkey_nxt    = '0;
        gcnt_nxt    = '0;
        gflags_nxt  = '0;
        obkt_nxt    = '0;
        members_nxt = '0;
        unique_nxt  = '0;
        rare_nxt    = '0;
        max_nxt     = '0;
      end else if (!have_r) begin
        have_nxt    = 1'b1;
        gkey_nxt    = key_r;
        gflags_nxt  = flags_r;
        gcnt_nxt    = start_cnt;
        obkt_nxt    = bkt_in;
        members_nxt = '0;
      end else if (key_r == gkey_r) begin
        gflags_nxt = gflags_r | flags_r;
        if (!mode_r) begin
          gcnt_nxt = sat_inc(gcnt_r);
        end
      end else begin
        unique_nxt  = uniq_c;
        members_nxt = mem_c;
        max_nxt     = max_c;
        rare_nxt    = rare_c;
        r0.kind     = KIND_UNIQUE;
        r0.key      = gkey_r;
        r0.occ      = gcnt_r;
        r0.flags    = gflags_r;
        r0.uniq     = uniq_c;
        r0.rare     = rare_c;
        r0.largest  = max_c;
        push_n      = 2'd1;
        if (bkt_in != obkt_r) begin
          r1.kind     = KIND_CLUSTER;
          r1.bkt      = obkt_r;
          r1.size     = mem_c;
          r1.uniq     = uniq_c;
          r1.rare     = rare_c;
          r1.largest  = max_c;
          push_n      = 2'd2;
          obkt_nxt    = bkt_in;
          members_nxt = '0;
        end
        gkey_nxt   = key_r;
        gflags_nxt = flags_r;
        gcnt_nxt   = start_cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= 1'b0;
      lb_r      <= '0;
      v_r       <= 1'b0;
      have_r    <= 1'b0;
      gkey_r    <= '0;
      gcnt_r    <= '0;
      gflags_r  <= '0;
      obkt_r    <= '0;
      members_r <= '0;
      unique_r  <= '0;
      rare_r    <= '0;
      max_r     <= '0;
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      cnt_r     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FIXED_WEIGHT: mode_r <= cfg_data[0];
          REG_LOWER_BOUND:  lb_r   <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        v_r <= 1'b1;
      end else if (adv) begin
        v_r <= 1'b0;
      end
      have_r    <= have_nxt;
      gkey_r    <= gkey_nxt;
      gcnt_r    <= gcnt_nxt;
      gflags_r  <= gflags_nxt;
      obkt_r    <= obkt_nxt;
      members_r <= members_nxt;
      unique_r  <= unique_nxt;
      rare_r    <= rare_nxt;
      max_r     <= max_nxt;
      wr_ptr_r  <= wr_ptr_r + PTR_W'(push_n);
      rd_ptr_r  <= rd_ptr_r + PTR_W'(pop);
      cnt_r     <= cnt_r + CNT_W'(push_n) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      key_r   <= in_key;
      flags_r <= in_flag_mask;
    end
    if (push_n != 2'd0) begin
      q_r[wr_ptr_r] <= r0;
    end
    if (push_n == 2'd2) begin
      q_r[wr_ptr_r + PTR_W'(1)] <= r1;
    end
  end

  assign hd                  = q_r[rd_ptr_r];
  assign out_valid           = cnt_r != '0;
  assign out_kind            = hd.kind;
  assign out_key             = hd.key;
  assign out_occurrences     = hd.occ;
  assign out_merged_flags    = hd.flags;
  assign out_bucket          = hd.bkt;
  assign out_cluster_size    = hd.size;
  assign out_unique_total    = hd.uniq;
  assign out_rare_total      = hd.rare;
  assign out_largest_cluster = hd.largest;
  assign out_last            = hd.last;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("result queue overflow");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> v_r)
    else $error("stall without a held item");

  a_members_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    members_r <= max_r)
    else $error("open cluster larger than largest cluster");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && key_r == '0) |=> (!have_r && unique_r == '0 && members_r == '0))
    else $error("stream state not cleared at end of stream");

  a_two_results_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push_n == 2'd2) |-> (cnt_r <= CNT_W'(DEPTH - 2)))
    else $error("two results pushed without room");

endmodule
`default_nettype wire

// ===== dv/sorted_key_group_aggregator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_group_aggregator_tb
// Drives record streams into the aggregator and checks every group, cluster
// and end-of-stream result. The check compares each result against a group
// and bucket tracker that this bench keeps itself. The bench writes both
// registers between phases; the input idles and the output stalls at random.
// ----------------------------------------------------------------------------
module sorted_key_group_aggregator_tb;
  import skga_pkg::*;

  localparam int BKT_BITS     = BUCKET_BITS_DEF;
  localparam int FIXED_COUNT  = FIXED_WEIGHT_DEF;
  localparam int PHASE_ITEMS  = 280;
  localparam int SETTLE_CYC   = 8;

  typedef struct {
    logic [KEY_W-1:0]  key;
    logic [WORD_W-1:0] flags;
  } record_t;

  typedef struct {
    logic                kind;
    logic [KEY_W-1:0]    key;
    logic [WORD_W-1:0]   occ;
    logic [WORD_W-1:0]   flags;
    logic [BKT_BITS-1:0] bucket;
    logic [WORD_W-1:0]   size;
    logic [WORD_W-1:0]   uniq;
    logic [WORD_W-1:0]   rare;
    logic [WORD_W-1:0]   largest;
    logic                last;
  } group_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_index = REG_FIXED_WEIGHT;
  logic [WORD_W-1:0] cfg_data = '0;

  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [KEY_W-1:0]  in_key = '0;
  logic [WORD_W-1:0] in_flag_mask = '0;

  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_kind;
  logic [KEY_W-1:0]    out_key;
  logic [WORD_W-1:0]   out_occurrences;
  logic [WORD_W-1:0]   out_merged_flags;
  logic [BKT_BITS-1:0] out_bucket;
  logic [WORD_W-1:0]   out_cluster_size;
  logic [WORD_W-1:0]   out_unique_total;
  logic [WORD_W-1:0]   out_rare_total;
  logic [WORD_W-1:0]   out_largest_cluster;
  logic                out_last;

  sorted_key_group_aggregator i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_key              (in_key),
    .in_flag_mask        (in_flag_mask),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_kind            (out_kind),
    .out_key             (out_key),
    .out_occurrences     (out_occurrences),
    .out_merged_flags    (out_merged_flags),
    .out_bucket          (out_bucket),
    .out_cluster_size    (out_cluster_size),
    .out_unique_total    (out_unique_total),
    .out_rare_total      (out_rare_total),
    .out_largest_cluster (out_largest_cluster),
    .out_last            (out_last)
  );

  always #5 clk = ~clk;

  record_t       record_q[$];
  group_result_t pending_results[$];
  int            queued_total = 0;
  int            items_taken = 0;
  int            mismatches = 0;
  logic          in_accepted = 1'b0;
  logic          quiet;

  // long idle-free stretch in the middle of the run
  assign quiet = (items_taken >= 600) && (items_taken < 1000);

  // tracker state
  logic                fw_mode = 1'b0;
  logic [WORD_W-1:0]   rare_bound = '0;
  logic                grp_open = 1'b0;
  logic [KEY_W-1:0]    grp_key = '0;
  logic [WORD_W-1:0]   grp_count = '0;
  logic [WORD_W-1:0]   grp_flags = '0;
  logic [BKT_BITS-1:0] cur_bucket = '0;
  logic [WORD_W-1:0]   bucket_keys = '0;
  logic [WORD_W-1:0]   keys_total = '0;
  logic [WORD_W-1:0]   rare_keys = '0;
  logic [WORD_W-1:0]   peak_bucket = '0;

  function automatic logic [WORD_W-1:0] bump(input logic [WORD_W-1:0] v);
    return (v == '1) ? v : v + WORD_W'(1);
  endfunction

  function automatic logic [BKT_BITS-1:0] bucket_of(input logic [KEY_W-1:0] k);
    return k[KEY_W-1 -: BKT_BITS];
  endfunction

  task automatic push_result(input logic kind, input logic [KEY_W-1:0] k,
                             input logic [WORD_W-1:0] occ, input logic [WORD_W-1:0] fl,
                             input logic [BKT_BITS-1:0] bkt,
                             input logic [WORD_W-1:0] size, input logic last);
    group_result_t r;
    r.kind    = kind;
    r.key     = k;
    r.occ     = occ;
    r.flags   = fl;
    r.bucket  = bkt;
    r.size    = size;
    r.uniq    = keys_total;
    r.rare    = rare_keys;
    r.largest = peak_bucket;
    r.last    = last;
    pending_results.push_back(r);
  endtask

  task automatic close_group();
    keys_total  = bump(keys_total);
    bucket_keys = bump(bucket_keys);
    if (bucket_keys > peak_bucket) peak_bucket = bucket_keys;
    if (grp_count < rare_bound) rare_keys = bump(rare_keys);
    push_result(KIND_UNIQUE, grp_key, grp_count, grp_flags, '0, '0, 1'b0);
  endtask

  task automatic open_group(input logic [KEY_W-1:0] k, input logic [WORD_W-1:0] fl);
    grp_open  = 1'b1;
    grp_key   = k;
    grp_flags = fl;
    grp_count = fw_mode ? WORD_W'(FIXED_COUNT) : WORD_W'(1);
  endtask

  task automatic aggregate_record(input logic [KEY_W-1:0] k, input logic [WORD_W-1:0] fl);
    if (k == '0) begin
      if (grp_open) begin
        close_group();
        push_result(KIND_CLUSTER, '0, '0, '0, cur_bucket, bucket_keys, 1'b1);
      end else begin
        push_result(KIND_CLUSTER, '0, '0, '0, '0, '0, 1'b1);
      end
      grp_open    = 1'b0;
      grp_key     = '0;
      grp_count   = '0;
      grp_flags   = '0;
      cur_bucket  = '0;
      bucket_keys = '0;
      keys_total  = '0;
      rare_keys   = '0;
      peak_bucket = '0;
    end else if (!grp_open) begin
      open_group(k, fl);
      cur_bucket  = bucket_of(k);
      bucket_keys = '0;
    end else if (k == grp_key) begin
      grp_flags = grp_flags | fl;
      if (!fw_mode) grp_count = bump(grp_count);
    end else begin
      close_group();
      if (bucket_of(k) != cur_bucket) begin
        push_result(KIND_CLUSTER, '0, '0, '0, cur_bucket, bucket_keys, 1'b0);
        cur_bucket  = bucket_of(k);
        bucket_keys = '0;
      end
      open_group(k, fl);
    end
  endtask

  task automatic check_field(input string name, input logic [KEY_W-1:0] exp_v,
                             input logic [KEY_W-1:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s mismatch: expected %h, got %h", name, exp_v, got_v);
      mismatches++;
    end
  endtask

  // monitor: register writes, input transfers, result transfers
  always @(posedge clk) begin
    group_result_t e;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FIXED_WEIGHT: fw_mode = cfg_data[0];
          REG_LOWER_BOUND:  rare_bound = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        aggregate_record(in_key, in_flag_mask);
        items_taken++;
      end
      in_accepted <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing expected");
          mismatches++;
        end else begin
          e = pending_results.pop_front();
          check_field("kind", KEY_W'(e.kind), KEY_W'(out_kind));
          check_field("out_key", e.key, out_key);
          check_field("occurrences", KEY_W'(e.occ), KEY_W'(out_occurrences));
          check_field("merged_flags", KEY_W'(e.flags), KEY_W'(out_merged_flags));
          check_field("bucket", KEY_W'(e.bucket), KEY_W'(out_bucket));
          check_field("cluster_size", KEY_W'(e.size), KEY_W'(out_cluster_size));
          check_field("unique_total", KEY_W'(e.uniq), KEY_W'(out_unique_total));
          check_field("rare_total", KEY_W'(e.rare), KEY_W'(out_rare_total));
          check_field("largest_cluster", KEY_W'(e.largest),
                      KEY_W'(out_largest_cluster));
          check_field("last", KEY_W'(e.last), KEY_W'(out_last));
        end
      end
    end else begin
      in_accepted <= 1'b0;
    end
  end

  // driver: input records and result-side stall
  always @(negedge clk) begin
    record_t rec;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (!in_valid || in_accepted) begin
        if (record_q.size() > 0 && (quiet || $urandom_range(99) >= 6)) begin
          rec = record_q.pop_front();
          in_valid     <= 1'b1;
          in_key       <= rec.key;
          in_flag_mask <= rec.flags;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= !quiet && ($urandom_range(99) < 6);
    end
  end

  task automatic add_rec(input logic [KEY_W-1:0] k, input logic [WORD_W-1:0] fl);
    record_t r;
    r.key   = k;
    r.flags = fl;
    record_q.push_back(r);
    queued_total++;
  endtask

  function automatic logic [WORD_W-1:0] rand_flags();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // one stream of groups; mostly sorted with bucket steps, some broken order
  task automatic queue_stream(input bit closed);
    logic [KEY_W-1:0] k;
    logic [KEY_W-1:0] r;
    int nkeys;
    int run;
    bit noisy;
    noisy = $urandom_range(99) < 15;
    nkeys = $urandom_range(1, 12);
    k = {$urandom, $urandom};
    if (k == '0) k = KEY_W'(1);
    for (int i = 0; i < nkeys; i++) begin
      run = ($urandom_range(49) == 0) ? $urandom_range(95, 105) : $urandom_range(1, 4);
      for (int j = 0; j < run; j++) add_rec(k, rand_flags());
      r = {$urandom, $urandom};
      if (noisy) begin
        case ($urandom_range(2))
          0:       k = r;
          1:       k = k - KEY_W'($urandom_range(1, 1000));
          default: k = {k[KEY_W-1 -: BKT_BITS] - BKT_BITS'(1), r[KEY_W-BKT_BITS-1:0]};
        endcase
      end else if ($urandom_range(3) == 0) begin
        k = {k[KEY_W-1 -: BKT_BITS] + BKT_BITS'($urandom_range(1, 3)),
             r[KEY_W-BKT_BITS-1:0]};
      end else begin
        k = k + KEY_W'($urandom_range(1, 1000));
      end
      if (k == '0) k = KEY_W'(1);
    end
    if (closed) add_rec('0, rand_flags());
  endtask

  task automatic write_regs(input logic mode, input logic [WORD_W-1:0] bound);
    logic [WORD_W-1:0] junk;
    junk = $urandom;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= REG_FIXED_WEIGHT;
    cfg_data  <= {junk[WORD_W-1:1], mode};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_index <= REG_LOWER_BOUND;
    cfg_data  <= bound;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    @(posedge clk);
    while (record_q.size() != 0 || in_valid || pending_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  initial begin
    logic              modes[6];
    logic [WORD_W-1:0] bounds[6];
    int                target;
    modes  = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
    bounds = '{32'd2, 32'd101, 32'd100, 32'hFFFF_FFFF, 32'd0, 32'd100};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_regs(1'b0, '0);
    // empty streams, repeated key with flag OR, bucket changes,
    // out-of-order keys, extreme keys and flags
    add_rec('0, '0);
    add_rec('0, '1);
    add_rec(64'd1, '0);
    add_rec(64'd1, '1);
    add_rec(64'd1, 32'h1);
    add_rec(64'd2, 32'hA5A5_A5A5);
    add_rec(64'h0002_0000_0000_0000, 32'h5A5A_5A5A);
    add_rec('1, '1);
    add_rec('1, '0);
    add_rec(64'h8000_0000_0000_0000, 32'h8000_0000);
    add_rec(64'h8000_0000_0000_0001, 32'h0000_0001);
    add_rec(64'd3, 32'h0F0F_0F0F);
    add_rec('0, 32'h1234_5678);
    add_rec('0, '0);
    add_rec(64'h7FFF_FFFF_FFFF_FFFF, 32'hFFFF_0000);
    add_rec('0, '0);
    drain();

    for (int p = 0; p < 6; p++) begin
      write_regs(modes[p], bounds[p]);
      target = queued_total + PHASE_ITEMS;
      while (queued_total < target) queue_stream($urandom_range(9) != 0);
      if (p == 5) add_rec('0, rand_flags());
      drain();
    end

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
